// ===== sv/range_add_range_sum_blocks_core_defines.svh =====
// Assertion macros shared by the range add / range sum block.
// Taken in by the controller and the datapath; needs clk and rst_n in scope.
`ifndef RANGE_ADD_RANGE_SUM_BLOCKS_CORE_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_BLOCKS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RARS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RARS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rars_pkg.sv =====
// Shared types and constants for the range add / range sum block.
// No dependencies; used by rars_ctrl, rars_dp and the top level.
`default_nettype none

package rars_pkg;

    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 64;
    localparam int DIV_STEPS = 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUM = 1'b1;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_DIV     = 8'b0000_0100,
        ST_SEED    = 8'b0000_1000,
        ST_WALK_RD = 8'b0001_0000,
        ST_WALK_EX = 8'b0010_0000,
        ST_FIN_MUL = 8'b0100_0000,
        ST_FIN_ADD = 8'b1000_0000
    } ctrl_state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic seed;
        logic rd;
        logic exec;
        logic fin_mul;
        logic fin_add;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic walk_done;
        logic is_sum;
        logic out_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/rars_ctrl.sv =====
// Sequencer for the range add / range sum block: clear pass, index split,
// block walk and result handoff. Depends on rars_pkg and the defines header.
`default_nettype none

`include "range_add_range_sum_blocks_core_defines.svh"

module rars_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    output rars_pkg::dp_cmd_t      cmd,
    input  wire rars_pkg::dp_sts_t sts
);

    rars_pkg::ctrl_state_t state_reg;
    rars_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rars_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != rars_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            rars_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = rars_pkg::ST_IDLE;
                end
            end
            rars_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rars_pkg::ST_DIV;
                end
            end
            rars_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = rars_pkg::ST_SEED;
                end
            end
            rars_pkg::ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = rars_pkg::ST_WALK_RD;
            end
            rars_pkg::ST_WALK_RD:
            begin
                if (sts.walk_done)
                begin
                    state_next = sts.is_sum ? rars_pkg::ST_FIN_MUL : rars_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = rars_pkg::ST_WALK_EX;
                end
            end
            rars_pkg::ST_WALK_EX:
            begin
                cmd.exec   = 1'b1;
                state_next = rars_pkg::ST_WALK_RD;
            end
            rars_pkg::ST_FIN_MUL:
            begin
                cmd.fin_mul = 1'b1;
                state_next  = rars_pkg::ST_FIN_ADD;
            end
            rars_pkg::ST_FIN_ADD:
            begin
                // hold the total until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.fin_add = 1'b1;
                    state_next  = rars_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rars_pkg::ST_CLEAR;
            end
        endcase
    end

    `RARS_ASSERT_NEXT(a_accept_starts_div, item_valid && !item_stall,
        state_reg == rars_pkg::ST_DIV, "accepted item did not start the index split")
    `RARS_ASSERT_NEXT(a_read_then_exec, cmd.rd, cmd.exec,
        "memory read not followed by its update step")
    `RARS_ASSERT_NOW(a_no_result_overwrite, cmd.fin_add, !sts.out_busy,
        "result loaded while previous one is stalled")

endmodule

`default_nettype wire

// ===== sv/rars_dp.sv =====
// Datapath: element and per-block memories, block/offset split, range
// walker, accumulators and output register. Depends on rars_pkg and defines.
`default_nettype none

`include "range_add_range_sum_blocks_core_defines.svh"

module rars_dp #(
    parameter int ARRAY_SIZE = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rars_pkg::dp_cmd_t                    cmd,
    output rars_pkg::dp_sts_t                         sts,
    input  wire logic                                 op,
    input  wire logic        [rars_pkg::IDX_W-1:0]    first_index,
    input  wire logic        [rars_pkg::IDX_W-1:0]    last_index,
    input  wire logic signed [rars_pkg::VAL_W-1:0]    add_value,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed      [rars_pkg::SUM_W-1:0]    range_sum
);

    localparam int IDX_W      = rars_pkg::IDX_W;
    localparam int VAL_W      = rars_pkg::VAL_W;
    localparam int SUM_W      = rars_pkg::SUM_W;
    localparam int NUM_BLOCKS = (ARRAY_SIZE + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int AW         = $clog2(ARRAY_SIZE);
    localparam int BW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OW         = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int RS         = IDX_W + OW;
    localparam int RM_W       = IDX_W + 2;
    localparam int RP_W       = IDX_W + RM_W;
    localparam int LIM_W      = $clog2(ARRAY_SIZE + BLOCK_SIZE + 1);
    localparam int IW         = (LIM_W > IDX_W + 1) ? LIM_W : IDX_W + 1;

    // rounded-up reciprocal of BLOCK_SIZE, exact for every IDX_W-bit index
    localparam logic [RM_W-1:0] RECIP = RM_W'((2 ** RS + BLOCK_SIZE - 1) / BLOCK_SIZE);

    // memories
    logic [SUM_W-1:0] elem_mem [ARRAY_SIZE];
    logic [SUM_W-1:0] lazy_mem [NUM_BLOCKS];
    logic [SUM_W-1:0] expl_mem [NUM_BLOCKS];

    logic [SUM_W-1:0] elem_rd_reg;
    logic [SUM_W-1:0] lazy_rd_reg;
    logic [SUM_W-1:0] expl_rd_reg;

    // control registers
    logic [AW-1:0]                  clr_reg,     clr_next;
    logic [rars_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                           out_valid_reg, out_valid_next;

    // payload registers
    logic             op_reg,       op_next;
    logic [IW-1:0]    hi_reg,       hi_next;
    logic [SUM_W-1:0] v_reg,        v_next;
    logic [IW-1:0]    i_reg,        i_next;
    logic [BW-1:0]    b_reg,        b_next;
    logic [OW-1:0]    off_reg,      off_next;
    logic [IDX_W-1:0] quo_reg,      quo_next;
    logic             whole_reg,    whole_next;
    logic [SUM_W-1:0] acc_reg,      acc_next;
    logic [SUM_W-1:0] lazy_acc_reg, lazy_acc_next;
    logic [SUM_W-1:0] prod_reg,     prod_next;
    logic [SUM_W-1:0] out_data_reg, out_data_next;

    logic [RP_W-1:0]  recip_prod;
    logic             whole_now;
    logic             is_add;
    logic             clr_in_blk;
    logic             blk_end;
    logic [IW-1:0]    last_ext;

    logic             elem_we,  lazy_we,  expl_we;
    logic [AW-1:0]    elem_wa;
    logic [BW-1:0]    blk_wa;
    logic [SUM_W-1:0] elem_wd,  lazy_wd,  expl_wd;

    assign is_add     = (op_reg == rars_pkg::OP_ADD);
    assign clr_in_blk = ({1'b0, clr_reg} < (AW + 1)'(NUM_BLOCKS));
    assign blk_end    = (off_reg == OW'(BLOCK_SIZE - 1));
    assign last_ext   = IW'(last_index);

    // block index by reciprocal multiply; the offset follows in the seed step
    assign recip_prod = RP_W'(quo_reg) * RP_W'(RECIP);

    // a whole block starts here and fits inside the range
    assign whole_now = (off_reg == '0) && ((i_reg + IW'(BLOCK_SIZE - 1)) <= hi_reg);

    assign sts.clr_last  = (clr_reg == AW'(ARRAY_SIZE - 1));
    assign sts.div_last  = (div_cnt_reg == rars_pkg::DIV_CNT_W'(rars_pkg::DIV_STEPS - 1));
    assign sts.walk_done = (i_reg > hi_reg);
    assign sts.is_sum    = (op_reg == rars_pkg::OP_SUM);
    assign sts.out_busy  = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign range_sum    = out_data_reg;

    // memory write ports
    always_comb
    begin
        elem_we = cmd.clr_step || (cmd.exec && is_add && !whole_reg);
        lazy_we = (cmd.clr_step && clr_in_blk) || (cmd.exec && is_add && whole_reg);
        expl_we = (cmd.clr_step && clr_in_blk) || (cmd.exec && is_add && !whole_reg);
        elem_wa = cmd.clr_step ? clr_reg : i_reg[AW-1:0];
        blk_wa  = cmd.clr_step ? clr_reg[BW-1:0] : b_reg;
        elem_wd = cmd.clr_step ? '0 : elem_rd_reg + v_reg;
        lazy_wd = cmd.clr_step ? '0 : lazy_rd_reg + v_reg;
        expl_wd = cmd.clr_step ? '0 : expl_rd_reg + v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_wa] <= elem_wd;
        end
        if (cmd.rd)
        begin
            elem_rd_reg <= elem_mem[i_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lazy_we)
        begin
            lazy_mem[blk_wa] <= lazy_wd;
        end
        if (cmd.rd)
        begin
            lazy_rd_reg <= lazy_mem[b_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (expl_we)
        begin
            expl_mem[blk_wa] <= expl_wd;
        end
        if (cmd.rd)
        begin
            expl_rd_reg <= expl_mem[b_reg];
        end
    end

    always_comb
    begin
        clr_next       = clr_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        hi_next        = hi_reg;
        v_next         = v_reg;
        i_next         = i_reg;
        b_next         = b_reg;
        off_next       = off_reg;
        quo_next       = quo_reg;
        whole_next     = whole_reg;
        acc_next       = acc_reg;
        lazy_acc_next  = lazy_acc_reg;
        prod_next      = prod_reg;
        out_data_next  = out_data_reg;

        if (cmd.clr_step)
        begin
            clr_next = clr_reg + AW'(1);
        end

        if (cmd.load)
        begin
            op_next       = op;
            hi_next       = (last_ext >= IW'(ARRAY_SIZE - 1)) ? IW'(ARRAY_SIZE - 1) : last_ext;
            v_next        = {{(SUM_W - VAL_W){add_value[VAL_W-1]}}, add_value};
            i_next        = IW'(first_index);
            quo_next      = first_index;
            div_cnt_next  = '0;
            acc_next      = '0;
            lazy_acc_next = '0;
        end

        if (cmd.div_step)
        begin
            quo_next     = IDX_W'(recip_prod >> RS);
            div_cnt_next = div_cnt_reg + rars_pkg::DIV_CNT_W'(1);
        end

        // i_reg still holds the first index here
        if (cmd.seed)
        begin
            b_next   = BW'(quo_reg);
            off_next = OW'(i_reg - IW'(quo_reg) * IW'(BLOCK_SIZE));
        end

        if (cmd.rd)
        begin
            whole_next = whole_now;
        end

        if (cmd.exec)
        begin
            if (whole_reg)
            begin
                if (!is_add)
                begin
                    acc_next      = acc_reg + expl_rd_reg;
                    lazy_acc_next = lazy_acc_reg + lazy_rd_reg;
                end
                i_next = i_reg + IW'(BLOCK_SIZE);
                b_next = b_reg + BW'(1);
            end
            else
            begin
                if (!is_add)
                begin
                    acc_next = acc_reg + elem_rd_reg + lazy_rd_reg;
                end
                i_next = i_reg + IW'(1);
                if (blk_end)
                begin
                    off_next = '0;
                    b_next   = b_reg + BW'(1);
                end
                else
                begin
                    off_next = off_reg + OW'(1);
                end
            end
        end

        // lazy adds of whole blocks count once per element
        if (cmd.fin_mul)
        begin
            prod_next = lazy_acc_reg * SUM_W'(BLOCK_SIZE);
        end

        if (result_valid && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fin_add)
        begin
            out_data_next  = acc_reg + prod_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        hi_reg       <= hi_next;
        v_reg        <= v_next;
        i_reg        <= i_next;
        b_reg        <= b_next;
        off_reg      <= off_next;
        quo_reg      <= quo_next;
        whole_reg    <= whole_next;
        acc_reg      <= acc_next;
        lazy_acc_reg <= lazy_acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    `RARS_ASSERT_NOW(a_read_in_array, cmd.rd, i_reg < IW'(ARRAY_SIZE),
        "walk read beyond the array")
    `RARS_ASSERT_NOW(a_whole_block_aligned, cmd.exec && whole_reg, off_reg == '0,
        "whole-block step off a block boundary")
    `RARS_ASSERT_NOW(a_split_complete, cmd.seed,
        div_cnt_reg == rars_pkg::DIV_CNT_W'(rars_pkg::DIV_STEPS),
        "block index taken before the divide finished")

endmodule

`default_nettype wire

// ===== sv/range_add_range_sum_blocks_core.sv =====
// Range add / range sum over a block-split array of signed 64-bit values.
// Top level; instantiates rars_ctrl and rars_dp, uses rars_pkg.
//
// Usage:
//  - Item channel (item_valid / item_stall): op, first_index, last_index,
//    add_value. op = add puts add_value on every element of the inclusive
//    range; op = sum returns the wrapped 64-bit total of the range.
//  - Result channel (result_valid / result_stall): range_sum, one transfer
//    per sum item, none for an add. Empty ranges add nothing and sum to 0;
//    last_index past the array end is clamped to the last element.
//  - One item is processed at a time. After its transfer an item runs the
//    index split, the seed step and S walk steps before item_stall drops
//    again (a sum adds a multiply step and an add step, the latter loading
//    the output register). S is the number of walk steps: one per element
//    of a partial block, one per whole block. Each walk step is a read then
//    a read-modify-write on the memories; with the defaults S is at most 92.
//  - After reset a clearing pass zeroes all memories, stepping through every
//    element address, with item_stall held high.
//  - A finished sum sits in the output register; the next item is taken
//    meanwhile, and its own result waits only if that register is stalled.
`default_nettype none

module range_add_range_sum_blocks_core #(
    parameter int ARRAY_SIZE = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_stall,
    input  wire logic                                 op,
    input  wire logic        [rars_pkg::IDX_W-1:0]    first_index,
    input  wire logic        [rars_pkg::IDX_W-1:0]    last_index,
    input  wire logic signed [rars_pkg::VAL_W-1:0]    add_value,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed      [rars_pkg::SUM_W-1:0]    range_sum
);

    rars_pkg::dp_cmd_t cmd;
    rars_pkg::dp_sts_t sts;

    // sequencer: owns the item handshake, issues one command set per cycle
    rars_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    // datapath: memories, walk counters, accumulators, result register
    rars_dp #(
        .ARRAY_SIZE (ARRAY_SIZE),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .first_index  (first_index),
        .last_index   (last_index),
        .add_value    (add_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .range_sum    (range_sum)
    );

endmodule

`default_nettype wire

// ===== tb/rars_tb_pkg.sv =====
// Range sum scoreboard for the range add / range sum block testbench.
// Depends on rars_pkg for the operation codes and field widths.
package rars_tb_pkg;

    localparam int unsigned ELEMS = 1024;
    localparam int unsigned BLK   = 32;
    localparam int unsigned NBLK  = (ELEMS + BLK - 1) / BLK;

    class range_sum_board;

        // shadow of the block's element, lazy add and explicit sum stores
        logic [rars_pkg::SUM_W-1:0] elem [ELEMS];
        logic [rars_pkg::SUM_W-1:0] lazy [NBLK];
        logic [rars_pkg::SUM_W-1:0] xsum [NBLK];
        logic [rars_pkg::SUM_W-1:0] sums_due [$];
        int unsigned                errors;

        function new();
            foreach (elem[i]) elem[i] = '0;
            foreach (lazy[i]) lazy[i] = '0;
            foreach (xsum[i]) xsum[i] = '0;
            errors = 0;
        endfunction

        // walks [lo, hi] block by block; adds v or returns the wrapped sum
        function logic [rars_pkg::SUM_W-1:0] walk_blocks(int unsigned lo, int unsigned hi,
                bit do_add, logic [rars_pkg::SUM_W-1:0] v);
            logic [rars_pkg::SUM_W-1:0] acc;
            int unsigned                i;
            int unsigned                top;
            int unsigned                b;
            acc = '0;
            i   = lo;
            top = (hi >= ELEMS) ? ELEMS - 1 : hi;
            while (i <= top && i < ELEMS) begin
                b = i / BLK;
                if (i % BLK == 0 && i + BLK - 1 <= top) begin
                    if (do_add)
                        lazy[b] += v;
                    else
                        acc += lazy[b] * 64'(BLK) + xsum[b];
                    i += BLK;
                end
                else begin
                    if (do_add) begin
                        elem[i] += v;
                        xsum[b] += v;
                    end
                    else
                        acc += elem[i] + lazy[b];
                    i++;
                end
            end
            return acc;
        endfunction

        function void note_item(logic o, logic [rars_pkg::IDX_W-1:0] f,
                                logic [rars_pkg::IDX_W-1:0] l,
                                logic [rars_pkg::VAL_W-1:0] v);
            logic [rars_pkg::SUM_W-1:0] v64;
            v64 = {{(rars_pkg::SUM_W-rars_pkg::VAL_W){v[rars_pkg::VAL_W-1]}}, v};
            if (o == rars_pkg::OP_SUM)
                sums_due.push_back(walk_blocks(f, l, 1'b0, '0));
            else
                void'(walk_blocks(f, l, 1'b1, v64));
        endfunction

        function void check_sum(logic [rars_pkg::SUM_W-1:0] got);
            logic [rars_pkg::SUM_W-1:0] want;
            if (sums_due.size() == 0) begin
                if (errors < 10)
                    $display("range_sum transfer with no sum pending: %h", got);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got !== want) begin
                if (errors < 10)
                    $display("range_sum mismatch: expected %h (%0d) got %h (%0d)",
                             want, $signed(want), got, $signed(got));
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for range_add_range_sum_blocks_core.
// Depends on rars_pkg (RTL) and rars_tb_pkg (range sum scoreboard).
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: clearing pass plus ~650 items at worst-case walk and stalls
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // allowance for a worst-case walk of 92 walk steps plus the end of a sum
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS  = 150;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // item channel
    logic                             item_valid  = 1'b0;
    logic                             item_stall;
    logic                             op          = rars_pkg::OP_ADD;
    logic [rars_pkg::IDX_W-1:0]       first_index = '0;
    logic [rars_pkg::IDX_W-1:0]       last_index  = '0;
    logic signed [rars_pkg::VAL_W-1:0] add_value  = '0;

    // result channel
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    logic signed [rars_pkg::SUM_W-1:0] range_sum;

    // idling knobs (percent of cycles) and the long receiver hold-off
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    logic        hold_rx   = 1'b0;
    int unsigned cycle_count = 0;

    rars_tb_pkg::range_sum_board board = new();

    range_add_range_sum_blocks_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .first_index  (first_index),
        .last_index   (last_index),
        .add_value    (add_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .range_sum    (range_sum)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** range_add_range_sum_blocks_core: FAILED **");
            $finish;
        end
    end

    // Receiver: random stall, forced high while a hold-off is running.
    always @(posedge clk)
        result_stall <= hold_rx || (stall_pct != 0 && $urandom_range(99) < stall_pct);

    // Result monitor: a transfer is a rising edge with valid high and stall low.
    // Values are read before this edge's updates land, so the order of
    // processes within the step does not matter.
    always @(posedge clk)
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
            board.check_sum(range_sum);

    // Offers one item, with random idle cycles first, and waits for its transfer.
    // Valid is left high afterwards so back-to-back items need no extra edge.
    task automatic send_item(input logic o, input logic [rars_pkg::IDX_W-1:0] f,
                             input logic [rars_pkg::IDX_W-1:0] l,
                             input logic [rars_pkg::VAL_W-1:0] v);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= o;
        first_index <= f;
        last_index  <= l;
        add_value   <= v;
        @(posedge clk);
        // X during reset must not look like a transfer
        while (item_stall !== 1'b0)
            @(posedge clk);
        board.note_item(o, f, l, v);
    endtask

    // Random items: mostly short spans and block-aligned spans, so both the
    // element walk and the whole-block path get heavy use; some empty ranges.
    task automatic send_random(input int unsigned n);
        int unsigned kind;
        int unsigned f;
        int unsigned l;
        int unsigned a;
        int unsigned b;
        logic        o;
        logic [rars_pkg::VAL_W-1:0] v;
        repeat (n)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                // empty: first past last
                f = $urandom_range(rars_tb_pkg::ELEMS - 1, 1);
                l = $urandom_range(f - 1, 0);
            end
            else if (kind < 40)
            begin
                f = $urandom_range(rars_tb_pkg::ELEMS - 1);
                l = f + $urandom_range(40);
                if (l > rars_tb_pkg::ELEMS - 1)
                    l = rars_tb_pkg::ELEMS - 1;
            end
            else if (kind < 65)
            begin
                // whole blocks, sometimes with ragged ends
                a = $urandom_range(rars_tb_pkg::NBLK - 1);
                b = $urandom_range(rars_tb_pkg::NBLK - 1, a);
                f = a * rars_tb_pkg::BLK +
                    (($urandom_range(3) == 0) ? $urandom_range(rars_tb_pkg::BLK - 1) : 0);
                l = b * rars_tb_pkg::BLK + rars_tb_pkg::BLK - 1 -
                    (($urandom_range(3) == 0) ? $urandom_range(rars_tb_pkg::BLK - 1) : 0);
            end
            else
            begin
                f = $urandom_range(rars_tb_pkg::ELEMS - 1);
                l = $urandom_range(rars_tb_pkg::ELEMS - 1, f);
            end
            o = $urandom_range(1) ? rars_pkg::OP_SUM : rars_pkg::OP_ADD;
            case ($urandom_range(9))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                default: v = $urandom();
            endcase
            send_item(o, rars_pkg::IDX_W'(f), rars_pkg::IDX_W'(l), v);
        end
    endtask

    // Receiver hold-off, counted here so the sender keeps offering meanwhile.
    task automatic hold_results(input int unsigned n);
        hold_rx <= 1'b1;
        repeat (n) @(posedge clk);
        hold_rx <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block runs its clearing pass first with
        // item_stall high; send_item simply waits it out.
        send_item(rars_pkg::OP_SUM, 10'd0,    10'd1023, '0);            // all zero
        send_item(rars_pkg::OP_ADD, 10'd0,    10'd1023, 32'h7FFF_FFFF); // largest positive
        send_item(rars_pkg::OP_ADD, 10'd0,    10'd1023, 32'h8000_0000); // most negative
        send_item(rars_pkg::OP_SUM, 10'd0,    10'd1023, '0);
        send_item(rars_pkg::OP_ADD, 10'd5,    10'd40,   32'd1000);      // two partial blocks
        send_item(rars_pkg::OP_ADD, 10'd32,   10'd63,   -32'sd7);       // exactly one block
        send_item(rars_pkg::OP_ADD, 10'd31,   10'd64,   32'd3);         // elem, block, elem
        send_item(rars_pkg::OP_SUM, 10'd31,   10'd64,   '0);
        send_item(rars_pkg::OP_SUM, 10'd0,    10'd0,    '0);
        send_item(rars_pkg::OP_ADD, 10'd1023, 10'd1023, 32'hFFFF_FFFF); // last element
        send_item(rars_pkg::OP_SUM, 10'd1023, 10'd1023, '0);
        send_item(rars_pkg::OP_ADD, 10'd600,  10'd599,  32'd12345);     // empty add
        send_item(rars_pkg::OP_SUM, 10'd600,  10'd599,  '0);            // empty sum
        send_item(rars_pkg::OP_SUM, 10'd1023, 10'd0,    '0);            // widest empty
        send_item(rars_pkg::OP_ADD, 10'd992,  10'd1023, 32'd77);        // last whole block
        send_item(rars_pkg::OP_SUM, 10'd960,  10'd1023, '0);
        send_item(rars_pkg::OP_ADD, 10'd1,    10'd1022, 32'hAAAA_AAAA);
        send_item(rars_pkg::OP_ADD, 10'd1,    10'd1022, 32'h5555_5555);
        send_item(rars_pkg::OP_SUM, 10'd1,    10'd1022, '0);
        send_item(rars_pkg::OP_SUM, 10'd0,    10'd31,   '0);
        send_item(rars_pkg::OP_SUM, 10'd33,   10'd62,   '0);            // inside one block
        send_item(rars_pkg::OP_SUM, 10'd0,    10'd1023, '0);

        // Back-pressure: receiver held off for a long stretch while items keep
        // coming, so the output register fills and the item side stalls.
        fork
            hold_results(1500);
        join_none
        send_random(12);

        // idling phases: none, sender gaps, receiver stalls, both
        send_random(PHASE_ITEMS);
        gap_pct = 68;
        send_random(PHASE_ITEMS);
        gap_pct = 0;
        stall_pct <= 68;
        send_random(PHASE_ITEMS);
        gap_pct = 37;
        stall_pct <= 37;
        send_random(PHASE_ITEMS);

        item_valid <= 1'b0;
        while (board.sums_due.size() != 0)
            @(posedge clk);
        // last item may be an add still walking; let it settle
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.sums_due.size() == 0)
            $display("** range_add_range_sum_blocks_core: PASSED **");
        else
            $display("** range_add_range_sum_blocks_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
